// ----- src/pu_pkg.sv -----
// Package: request/response payload types, address map constants and claim arbitration.
`timescale 1ns / 1ps
package pu_pkg;

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;

  localparam logic [31:0] UART_ORIGIN = 32'h1000_0000;
  localparam logic [31:0] PLIC_ORIGIN = 32'h0c00_0000;
  localparam logic [31:0] PLIC_SPAN = 32'h0040_0000;
  localparam logic [21:0] PEND_OFS  = 22'h00_1000;
  localparam logic [21:0] ENAB_OFS  = 22'h00_2000;
  localparam logic [21:0] CTX_OFS   = 22'h20_0000;
  localparam logic [21:0] CLAIM_OFS = 22'h20_0004;
  localparam logic [21:0] PRIO_LO   = 22'd4;
  localparam logic [21:0] PRIO_HI   = 22'd12;

  localparam logic [2:0] UREG_RBR = 3'd0;
  localparam logic [2:0] UREG_IER = 3'd1;
  localparam logic [2:0] UREG_IIR = 3'd2;
  localparam logic [2:0] UREG_LCR = 3'd3;
  localparam logic [2:0] UREG_MCR = 3'd4;
  localparam logic [2:0] UREG_LSR = 3'd5;
  localparam logic [2:0] UREG_SCR = 3'd7;

  localparam logic [7:0] IIR_RX_DATA  = 8'hC4;
  localparam logic [7:0] IIR_THR_EMPT = 8'hC2;
  localparam logic [7:0] IIR_NONE     = 8'hC1;
  localparam logic [7:0] LSR_BASE     = 8'h60;
  localparam logic [3:0] IER_MASK     = 4'h0f;
  localparam int         DLAB_POS     = 7;
  localparam int         IER_RX_POS   = 0;
  localparam int         IER_THR_POS  = 1;

  localparam logic [31:0] USB_SRC = 32'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] address;
    logic [31:0] write_data;
    logic        rx_available;
    logic [7:0]  rx_byte;
    logic        usb_irq;
    logic        net_irq;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        rx_pop;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        usb_irq_done;
    logic        ext_irq;
  } rsp_t;

  typedef logic [2:0][31:0] prio_t;

  // Strictly-greater scan from the threshold; lower source wins ties.
  function automatic logic [1:0] best_claim(prio_t prio, logic [31:0] enable,
                                            logic [31:0] thr, logic [3:1] pend);
    logic [1:0]  win;
    logic [31:0] top;
    win = 2'd0;
    top = thr;
    for (int s = 1; s <= 3; s++) begin
      if (enable[s] && pend[s] && (prio[s-1] > top)) begin
        win = 2'(s);
        top = prio[s-1];
      end
    end
    return win;
  endfunction

endpackage

// ----- src/pu_req_if.sv -----
// Request channel interface: valid/ready handshake with request payload.
`timescale 1ns / 1ps
interface pu_req_if;
  logic          valid;
  logic          ready;
  pu_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/pu_rsp_if.sv -----
// Response channel interface: valid/ready handshake with response payload.
`timescale 1ns / 1ps
interface pu_rsp_if;
  logic          valid;
  logic          ready;
  pu_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/plic_and_uart_register_block.sv -----
// PLIC and 16550 UART register block: input register, decode/update, result register.
// Flow: an accepted request is held in the input register, decoded from it, and its
// response is captured in the result register, which drives the response channel.
// Throughput: one transfer per cycle; a held response stalls the input register.
// Reset (synchronous, rst high): pipeline empty, priorities 1, tx-empty pending set,
// all other registers zero.
`timescale 1ns / 1ps
module plic_and_uart_register_block (
  input  logic        clk,
  input  logic        rst,
  pu_req_if.sink      req,
  pu_rsp_if.source    rsp
);
  import pu_pkg::*;

  logic        item_valid;
  req_t        item;
  logic        rsp_valid;
  rsp_t        rsp_data;

  prio_t       source_priority, source_priority_next;
  logic [31:0] source_enable, source_enable_next;
  logic [31:0] claim_threshold, claim_threshold_next;
  logic [15:0] baud_divisor, baud_divisor_next;
  logic [3:0]  irq_enable_bits, irq_enable_bits_next;
  logic [7:0]  line_control, line_control_next;
  logic [7:0]  modem_control, modem_control_next;
  logic [7:0]  scratch_byte, scratch_byte_next;
  logic        tx_empty_pending, tx_empty_pending_next;

  logic        advance, fire;
  rsp_t        result;
  logic        dlab, plic_hit, prio_hit, uart_hit;
  logic [21:0] ofs;
  logic [1:0]  prio_idx;
  logic [2:0]  uart_reg;
  logic [3:1]  pend, pend_next;
  logic [1:0]  claim_now, claim_next;

  assign advance   = !rsp_valid || rsp.ready;
  assign fire      = item_valid && advance;
  assign req.ready = !item_valid || advance;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  always_comb begin
    dlab     = line_control[DLAB_POS];
    plic_hit = (item.address >= PLIC_ORIGIN) && (item.address < PLIC_ORIGIN + PLIC_SPAN);
    ofs      = item.address[21:0];
    prio_hit = (ofs >= PRIO_LO) && (ofs <= PRIO_HI);
    prio_idx = ofs[3:2] - 2'd1;
    uart_hit = item.address[31:3] == UART_ORIGIN[31:3];
    uart_reg = item.address[2:0];

    pend[1] = (irq_enable_bits[IER_RX_POS] && item.rx_available) ||
              (irq_enable_bits[IER_THR_POS] && tx_empty_pending);
    pend[2] = item.usb_irq;
    pend[3] = item.net_irq;
    claim_now = best_claim(source_priority, source_enable, claim_threshold, pend);

    source_priority_next  = source_priority;
    source_enable_next    = source_enable;
    claim_threshold_next  = claim_threshold;
    baud_divisor_next     = baud_divisor;
    irq_enable_bits_next  = irq_enable_bits;
    line_control_next     = line_control;
    modem_control_next    = modem_control;
    scratch_byte_next     = scratch_byte;
    tx_empty_pending_next = tx_empty_pending;
    result                = '0;

    case (item.req_type)
      REQ_READ: begin
        if (plic_hit) begin
          if (prio_hit) begin
            result.read_data = source_priority[prio_idx];
          end else if (ofs == PEND_OFS) begin
            result.read_data = {28'd0, pend, 1'b0};
          end else if (ofs == ENAB_OFS) begin
            result.read_data = source_enable;
          end else if (ofs == CTX_OFS) begin
            result.read_data = claim_threshold;
          end else if (ofs == CLAIM_OFS) begin
            result.read_data = {30'd0, claim_now};
          end
        end else if (uart_hit) begin
          case (uart_reg)
            UREG_RBR: begin
              if (dlab) begin
                result.read_data = {24'd0, baud_divisor[7:0]};
              end else if (item.rx_available) begin
                result.read_data = {24'd0, item.rx_byte};
                result.rx_pop    = 1'b1;
              end
            end
            UREG_IER: begin
              result.read_data = dlab ? {24'd0, baud_divisor[15:8]}
                                      : {28'd0, irq_enable_bits};
            end
            UREG_IIR: begin
              if (irq_enable_bits[IER_RX_POS] && item.rx_available) begin
                result.read_data = {24'd0, IIR_RX_DATA};
              end else if (irq_enable_bits[IER_THR_POS] && tx_empty_pending) begin
                result.read_data      = {24'd0, IIR_THR_EMPT};
                tx_empty_pending_next = 1'b0;
              end else begin
                result.read_data = {24'd0, IIR_NONE};
              end
            end
            UREG_LCR: result.read_data = {24'd0, line_control};
            UREG_MCR: result.read_data = {24'd0, modem_control};
            UREG_LSR: result.read_data = {24'd0, LSR_BASE[7:1], item.rx_available};
            UREG_SCR: result.read_data = {24'd0, scratch_byte};
            default:  result.read_data = '0;
          endcase
        end
      end
      REQ_WRITE: begin
        if (plic_hit) begin
          if (prio_hit) begin
            source_priority_next[prio_idx] = item.write_data;
          end else if (ofs == ENAB_OFS) begin
            source_enable_next = item.write_data;
          end else if (ofs == CTX_OFS) begin
            claim_threshold_next = item.write_data;
          end else if (ofs == CLAIM_OFS) begin
            result.usb_irq_done = item.write_data == USB_SRC;
          end
        end else if (uart_hit) begin
          case (uart_reg)
            UREG_RBR: begin
              if (dlab) begin
                baud_divisor_next[7:0] = item.write_data[7:0];
              end else begin
                result.tx_valid       = 1'b1;
                result.tx_byte        = item.write_data[7:0];
                tx_empty_pending_next = 1'b1;
              end
            end
            UREG_IER: begin
              if (dlab) begin
                baud_divisor_next[15:8] = item.write_data[7:0];
              end else begin
                irq_enable_bits_next = item.write_data[3:0] & IER_MASK;
                if (irq_enable_bits_next[IER_THR_POS] && !irq_enable_bits[IER_THR_POS]) begin
                  tx_empty_pending_next = 1'b1;
                end
                if (!irq_enable_bits_next[IER_THR_POS]) begin
                  tx_empty_pending_next = 1'b0;
                end
              end
            end
            UREG_LCR: line_control_next  = item.write_data[7:0];
            UREG_MCR: modem_control_next = item.write_data[7:0];
            UREG_SCR: scratch_byte_next  = item.write_data[7:0];
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    // interrupt level reflects state after this transfer
    pend_next[1] = (irq_enable_bits_next[IER_RX_POS] && item.rx_available) ||
                   (irq_enable_bits_next[IER_THR_POS] && tx_empty_pending_next);
    pend_next[2] = item.usb_irq;
    pend_next[3] = item.net_irq;
    claim_next = best_claim(source_priority_next, source_enable_next,
                            claim_threshold_next, pend_next);
    result.ext_irq = claim_next != 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid       <= 1'b0;
      rsp_valid        <= 1'b0;
      source_priority  <= {32'd1, 32'd1, 32'd1};
      source_enable    <= '0;
      claim_threshold  <= '0;
      baud_divisor     <= '0;
      irq_enable_bits  <= '0;
      line_control     <= '0;
      modem_control    <= '0;
      scratch_byte     <= '0;
      tx_empty_pending <= 1'b1;
    end else begin
      if (req.ready) begin
        item_valid <= req.valid;
      end
      if (advance) begin
        rsp_valid <= item_valid;
      end
      if (fire) begin
        source_priority  <= source_priority_next;
        source_enable    <= source_enable_next;
        claim_threshold  <= claim_threshold_next;
        baud_divisor     <= baud_divisor_next;
        irq_enable_bits  <= irq_enable_bits_next;
        line_control     <= line_control_next;
        modem_control    <= modem_control_next;
        scratch_byte     <= scratch_byte_next;
        tx_empty_pending <= tx_empty_pending_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      item <= req.data;
    end
    if (fire) begin
      rsp_data <= result;
    end
  end

endmodule

// ----- dv/plic_uart_checker.sv -----
// Checker: predicts each register access response and compares it with the block's output.
`timescale 1ns / 1ps
module plic_uart_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_ready,
  input  pu_pkg::req_t  req_data,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  pu_pkg::rsp_t  rsp_data,
  output int            errors,
  output int            outstanding
);
  import pu_pkg::*;

  logic [31:0] prio [1:3];
  logic [31:0] src_en;
  logic [31:0] thresh;
  logic [15:0] divisor;
  logic [3:0]  ier;
  logic [7:0]  lcr;
  logic [7:0]  mcr;
  logic [7:0]  scr;
  logic        thre;

  rsp_t rsp_fifo[$];
  rsp_t want;
  int   fail_cnt = 0;
  int   depth = 0;

  assign errors      = fail_cnt;
  assign outstanding = depth;

  function automatic logic [3:1] pend_vec(input logic rx, input logic usb, input logic net);
    return {net, usb, (ier[IER_RX_POS] && rx) || (ier[IER_THR_POS] && thre)};
  endfunction

  function automatic logic [1:0] claim_winner(input logic rx, input logic usb,
                                              input logic net);
    logic [3:1]  p;
    logic [1:0]  win;
    logic [31:0] top_prio;
    p        = pend_vec(rx, usb, net);
    win      = 2'd0;
    top_prio = thresh;
    for (int s = 1; s <= 3; s++) begin
      if (src_en[s] && p[s] && (prio[s] > top_prio)) begin
        win      = 2'(s);
        top_prio = prio[s];
      end
    end
    return win;
  endfunction

  // Applies one access to the shadow registers and returns the response it produces.
  function automatic rsp_t register_access(input req_t r);
    rsp_t        o;
    logic [21:0] ofs;
    logic        dlab;
    logic        in_plic;
    logic        in_uart;
    logic [3:0]  old_ier;
    o       = '0;
    dlab    = lcr[DLAB_POS];
    in_plic = (r.address >= PLIC_ORIGIN) && (r.address < PLIC_ORIGIN + PLIC_SPAN);
    in_uart = (r.address[31:3] == UART_ORIGIN[31:3]);
    ofs     = 22'(r.address - PLIC_ORIGIN);
    if (r.req_type == REQ_READ) begin
      if (in_plic) begin
        if (ofs >= PRIO_LO && ofs <= PRIO_HI) begin
          o.read_data = prio[ofs[3:2]];
        end else if (ofs == PEND_OFS) begin
          o.read_data = {28'd0, pend_vec(r.rx_available, r.usb_irq, r.net_irq), 1'b0};
        end else if (ofs == ENAB_OFS) begin
          o.read_data = src_en;
        end else if (ofs == CTX_OFS) begin
          o.read_data = thresh;
        end else if (ofs == CLAIM_OFS) begin
          o.read_data = {30'd0, claim_winner(r.rx_available, r.usb_irq, r.net_irq)};
        end
      end else if (in_uart) begin
        case (r.address[2:0])
          UREG_RBR: begin
            if (dlab) begin
              o.read_data = {24'd0, divisor[7:0]};
            end else if (r.rx_available) begin
              o.read_data = {24'd0, r.rx_byte};
              o.rx_pop    = 1'b1;
            end
          end
          UREG_IER: o.read_data = dlab ? {24'd0, divisor[15:8]} : {28'd0, ier};
          UREG_IIR: begin
            if (ier[IER_RX_POS] && r.rx_available) begin
              o.read_data = {24'd0, IIR_RX_DATA};
            end else if (ier[IER_THR_POS] && thre) begin
              thre        = 1'b0;
              o.read_data = {24'd0, IIR_THR_EMPT};
            end else begin
              o.read_data = {24'd0, IIR_NONE};
            end
          end
          UREG_LCR: o.read_data = {24'd0, lcr};
          UREG_MCR: o.read_data = {24'd0, mcr};
          UREG_LSR: o.read_data = {24'd0, LSR_BASE | {7'd0, r.rx_available}};
          UREG_SCR: o.read_data = {24'd0, scr};
          default: ;
        endcase
      end
    end else if (r.req_type == REQ_WRITE) begin
      if (in_plic) begin
        if (ofs >= PRIO_LO && ofs <= PRIO_HI) begin
          prio[ofs[3:2]] = r.write_data;
        end else if (ofs == ENAB_OFS) begin
          src_en = r.write_data;
        end else if (ofs == CTX_OFS) begin
          thresh = r.write_data;
        end else if (ofs == CLAIM_OFS && r.write_data == USB_SRC) begin
          o.usb_irq_done = 1'b1;
        end
      end else if (in_uart) begin
        case (r.address[2:0])
          UREG_RBR: begin
            if (dlab) begin
              divisor[7:0] = r.write_data[7:0];
            end else begin
              o.tx_valid = 1'b1;
              o.tx_byte  = r.write_data[7:0];
              thre       = 1'b1;
            end
          end
          UREG_IER: begin
            if (dlab) begin
              divisor[15:8] = r.write_data[7:0];
            end else begin
              old_ier = ier;
              ier     = r.write_data[3:0] & IER_MASK;
              if (ier[IER_THR_POS] && !old_ier[IER_THR_POS]) thre = 1'b1;
              if (!ier[IER_THR_POS]) thre = 1'b0;
            end
          end
          UREG_LCR: lcr = r.write_data[7:0];
          UREG_MCR: mcr = r.write_data[7:0];
          UREG_SCR: scr = r.write_data[7:0];
          default: ;
        endcase
      end
    end
    o.ext_irq = (claim_winner(r.rx_available, r.usb_irq, r.net_irq) != 2'd0);
    return o;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] got_val);
    if (exp_val !== got_val) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("mismatch on %s: expected %h, got %h", name, exp_val, got_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      prio[1] = 32'd1;
      prio[2] = 32'd1;
      prio[3] = 32'd1;
      src_en  = '0;
      thresh  = '0;
      divisor = '0;
      ier     = '0;
      lcr     = '0;
      mcr     = '0;
      scr     = '0;
      thre    = 1'b1;
      rsp_fifo.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (rsp_fifo.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("response transfer with no request outstanding");
        end else begin
          want = rsp_fifo.pop_front();
          check_field("read_data", want.read_data, rsp_data.read_data);
          check_field("rx_pop", 32'(want.rx_pop), 32'(rsp_data.rx_pop));
          check_field("tx_valid", 32'(want.tx_valid), 32'(rsp_data.tx_valid));
          check_field("tx_byte", 32'(want.tx_byte), 32'(rsp_data.tx_byte));
          check_field("usb_irq_done", 32'(want.usb_irq_done),
                      32'(rsp_data.usb_irq_done));
          check_field("ext_irq", 32'(want.ext_irq), 32'(rsp_data.ext_irq));
        end
      end
      if (req_valid && req_ready) rsp_fifo.push_back(register_access(req_data));
    end
    depth <= rsp_fifo.size();
  end

endmodule

// ----- dv/tb_plic_and_uart_register_block.sv -----
// Testbench top: clock, reset, request stimulus, response back-pressure and verdict.
`timescale 1ns / 1ps
module tb_plic_and_uart_register_block;
  import pu_pkg::*;

  localparam logic [1:0] REQ_POLL    = 2'd2;
  localparam logic [1:0] REQ_RSVD    = 2'd3;
  localparam logic [2:0] UREG_MSR    = 3'd6;
  localparam int         RANDOM_ITEMS = 1800;
  localparam int         CYCLE_LIMIT  = 400000;

  logic clk;
  logic rst;
  int   errors;
  int   outstanding;
  int   cycles = 0;
  int   burst_left = 0;

  pu_req_if req_ch ();
  pu_rsp_if rsp_ch ();

  plic_and_uart_register_block uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  plic_uart_checker chk (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_ch.valid),
    .req_ready   (req_ch.ready),
    .req_data    (req_ch.data),
    .rsp_valid   (rsp_ch.valid),
    .rsp_ready   (rsp_ch.ready),
    .rsp_data    (rsp_ch.data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Response back-pressure: ready follows a repeating 16-bit stall mask that is redrawn at random.
  initial begin
    logic [15:0] stall_mask;
    int          slot;
    stall_mask = '0;
    slot       = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (slot % 256 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_mask = '0;
          1: stall_mask = 16'($urandom);
          2: stall_mask = 16'($urandom & $urandom);
          default: stall_mask = 16'hff00;
        endcase
      end
      rsp_ch.ready <= !stall_mask[slot % 16];
      slot++;
    end
  end

  function automatic req_t acc(input logic [1:0] kind, input logic [31:0] addr,
                               input logic [31:0] wdata);
    req_t r;
    r.req_type     = kind;
    r.address      = addr;
    r.write_data   = wdata;
    r.rx_available = 1'($urandom_range(0, 1));
    r.rx_byte      = 8'($urandom_range(0, 255));
    r.usb_irq      = 1'($urandom_range(0, 1));
    r.net_irq      = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic logic [31:0] pick_address();
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4, 5: return UART_ORIGIN + $urandom_range(0, 7);
      6, 7:             return PLIC_ORIGIN + $urandom_range(0, 15);
      8:                return PLIC_ORIGIN + PEND_OFS;
      9, 10:            return PLIC_ORIGIN + ENAB_OFS;
      11:               return PLIC_ORIGIN + CTX_OFS;
      12, 13:           return PLIC_ORIGIN + CLAIM_OFS;
      14: begin
        case ($urandom_range(0, 5))
          0: return PLIC_ORIGIN + PEND_OFS + $urandom_range(1, 3);
          1: return PLIC_ORIGIN + CLAIM_OFS + $urandom_range(1, 4);
          2: return PLIC_ORIGIN + PLIC_SPAN - $urandom_range(1, 2);
          3: return PLIC_ORIGIN + PLIC_SPAN;
          4: return PLIC_ORIGIN - 1;
          default: return UART_ORIGIN + 8;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_data();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return $urandom_range(0, 4);
      4:          return $urandom;
      5:          return 32'h80 | $urandom_range(0, 3);
      6:          return $urandom_range(0, 255);
      default:    return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
    endcase
  endfunction

  function automatic logic [1:0] pick_kind();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 9) return REQ_READ;
    if (roll < 17) return REQ_WRITE;
    if (roll < 19) return REQ_POLL;
    return REQ_RSVD;
  endfunction

  // Sends one request; between bursts the sender idles for a random gap.
  task automatic issue(input req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
      repeat (gap) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 12);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    req_t r;
    int   counted;
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset values, priority window edges
    issue(acc(REQ_READ, PLIC_ORIGIN + PRIO_LO, 32'h0));
    issue(acc(REQ_READ, PLIC_ORIGIN + 32'd7, 32'h0));
    issue(acc(REQ_READ, PLIC_ORIGIN + 32'd13, 32'h0));
    r = acc(REQ_READ, UART_ORIGIN + UREG_IIR, 32'h0);
    r.rx_available = 1'b0;
    issue(r);
    // THR-empty enable sets the flag, IIR read clears it
    issue(acc(REQ_WRITE, UART_ORIGIN + UREG_IER, 32'hffff_fff2));
    issue(r);
    issue(r);
    issue(acc(REQ_WRITE, UART_ORIGIN + UREG_IER, 32'h1));
    r.rx_available = 1'b1;
    issue(r);
    // claim arbitration with extreme priority and threshold
    issue(acc(REQ_WRITE, PLIC_ORIGIN + ENAB_OFS, 32'hffff_ffff));
    issue(acc(REQ_WRITE, PLIC_ORIGIN + PRIO_HI, 32'hffff_ffff));
    issue(acc(REQ_WRITE, PLIC_ORIGIN + CTX_OFS, 32'hffff_fffe));
    r = acc(REQ_READ, PLIC_ORIGIN + CLAIM_OFS, 32'h0);
    r.usb_irq = 1'b1;
    r.net_irq = 1'b1;
    issue(r);
    issue(acc(REQ_WRITE, PLIC_ORIGIN + CTX_OFS, 32'hffff_ffff));
    issue(r);
    issue(acc(REQ_WRITE, PLIC_ORIGIN + CLAIM_OFS, USB_SRC));
    issue(acc(REQ_WRITE, PLIC_ORIGIN + CTX_OFS, 32'h0));
    // transmit, receive with and without a waiting byte
    issue(acc(REQ_WRITE, UART_ORIGIN + UREG_RBR, 32'hffff_ffa5));
    r = acc(REQ_READ, UART_ORIGIN + UREG_RBR, 32'h0);
    r.rx_available = 1'b1;
    r.rx_byte      = 8'hff;
    issue(r);
    r.rx_available = 1'b0;
    issue(r);
    // divisor latch access
    issue(acc(REQ_WRITE, UART_ORIGIN + UREG_LCR, 32'h80));
    issue(acc(REQ_WRITE, UART_ORIGIN + UREG_IER, 32'h1_00ab));
    issue(acc(REQ_READ, UART_ORIGIN + UREG_IER, 32'h0));
    issue(acc(REQ_WRITE, UART_ORIGIN + UREG_LCR, 32'h3));
    // FCR write, MSR read, reserved request type, unmapped address
    issue(acc(REQ_WRITE, UART_ORIGIN + UREG_IIR, 32'hc7));
    issue(acc(REQ_READ, UART_ORIGIN + UREG_MSR, 32'h0));
    issue(acc(REQ_RSVD, UART_ORIGIN + UREG_SCR, 32'hffff_ffff));
    issue(acc(REQ_WRITE, 32'hffff_ffff, 32'hffff_ffff));
    issue(acc(REQ_READ, 32'h0, 32'h0));
    drain();

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      r = acc(pick_kind(), pick_address(), pick_data());
      issue(r);
      counted++;
      if ($urandom_range(0, 299) == 0) drain();
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/pu_pkg.sv
src/pu_req_if.sv
src/pu_rsp_if.sv
src/plic_and_uart_register_block.sv
dv/plic_uart_checker.sv
dv/tb_plic_and_uart_register_block.sv
